// ===== src/aebr_pkg.sv =====
// shared types, constants and mode decode for the banked register file
`default_nettype none
package aebr_pkg;

  localparam logic [13:0] FIQ_SOURCES  = 14'h2040;
  localparam logic [13:0] IRQ_SOURCES  = 14'h1F9F;
  localparam logic [31:0] FIQ_VECTOR   = 32'h0000_001C;
  localparam logic [31:0] IRQ_VECTOR   = 32'h0000_0018;
  localparam logic [31:0] PC_OFFSET    = 32'd8;
  localparam logic [31:0] LINK_OFFSET  = 32'd4;
  localparam logic [31:0] FIQ_PC       = FIQ_VECTOR + PC_OFFSET;
  localparam logic [31:0] IRQ_PC       = IRQ_VECTOR + PC_OFFSET;
  localparam logic [31:0] STATUS_RESET = 32'h0000_00D3;

  localparam int BIT_T = 5;
  localparam int BIT_F = 6;
  localparam int BIT_I = 7;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam logic [2:0] BANK_USR = 3'd0;
  localparam logic [2:0] BANK_FIQ = 3'd1;
  localparam logic [2:0] BANK_IRQ = 3'd2;
  localparam logic [2:0] BANK_SVC = 3'd3;
  localparam logic [2:0] BANK_ABT = 3'd4;
  localparam logic [2:0] BANK_UND = 3'd5;

  localparam logic [3:0] FIQ_HIGH_BASE = 4'd5;
  localparam logic [2:0] STEP_R13      = 3'd5;
  localparam logic [2:0] STEP_R14      = 3'd6;
  localparam logic [2:0] STEP_SPSR     = 3'd7;

  localparam logic [4:0] IDX_SAVED  = 5'd16;
  localparam logic [4:0] IDX_STATUS = 5'd17;

  localparam logic [1:0] TAKEN_NONE = 2'd0;
  localparam logic [1:0] TAKEN_FIQ  = 2'd1;
  localparam logic [1:0] TAKEN_IRQ  = 2'd2;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SAVE,
    S_LOAD,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FIQ,
    ACT_IRQ,
    ACT_STATUS,
    ACT_ERR,
    ACT_WREG,
    ACT_READ
  } act_t;

  typedef enum logic [1:0] {
    FOP_IDLE,
    FOP_SAVE,
    FOP_LOAD,
    FOP_COMMIT
  } fop_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] num;
  } bank_t;

  typedef struct packed {
    fop_t        op;
    logic [2:0]  step;
    logic [2:0]  cur;
    logic [2:0]  nxt;
    act_t        act;
    logic [4:0]  idx;
    logic [31:0] val;
  } ctl_t;

  typedef struct packed {
    logic       push;
    logic [1:0] taken;
    logic       err;
  } res_t;

  function automatic bank_t bank_of(input logic [4:0] mode);
    bank_t b;
    b.ok = 1'b1;
    case (mode)
      MODE_USR, MODE_SYS: b.num = BANK_USR;
      MODE_FIQ: b.num = BANK_FIQ;
      MODE_IRQ: b.num = BANK_IRQ;
      MODE_SVC: b.num = BANK_SVC;
      MODE_ABT: b.num = BANK_ABT;
      MODE_UND: b.num = BANK_UND;
      default: begin
        b.ok  = 1'b0;
        b.num = BANK_USR;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== src/arm_exception_entry_and_register_banking.sv =====
// Register file for r8-r15 (r8-r14 banked by mode) with FIQ/IRQ entry. An item
// is decoded in the cycle after acceptance; reads, register writes, polls that
// take no exception and status writes that keep the mode then complete once the
// output register is free. Any mode change (status write or exception entry)
// first moves the banked r8-r14 and saved status out to and back in from the
// bank store through a single-word transfer path, one word per cycle, and then
// completes the same way. in_tready is high again in the cycle
// after the result is loaded into the output register, which holds it until
// taken; an invalid mode in a status write sets mode_error and changes nothing.
`default_nettype none
module arm_exception_entry_and_register_banking import aebr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [13:0] cfg_wdata,      // irq_enable_mask
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,       // cmd, reg_index, write_value, irq_latch, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata       // read_data, taken, mode_error, zero pad
);

  logic [13:0] mask_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        busy;
  logic        in_go;
  logic        out_free;
  logic [31:0] status;
  logic [31:0] rd;
  ctl_t        ctl;
  res_t        res;

  assign in_tready  = !busy;
  assign in_go      = in_tvalid && !busy;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  aebr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_go    (in_go),
    .cmd      (in_tdata[1:0]),
    .idx      (in_tdata[6:2]),
    .val      (in_tdata[38:7]),
    .latch    (in_tdata[52:39]),
    .mask     (mask_r),
    .status   (status),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl),
    .res      (res)
  );

  aebr_file u_file (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .status (status),
    .rd     (rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      if (res.push) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) out_data_r <= {5'd0, res.err, res.taken, rd};
  end

endmodule
`default_nettype wire

// ===== src/aebr_file.sv =====
// register file with banked copies and the one-word transfer path
`default_nettype none
module aebr_file import aebr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  output logic [31:0]      status,
  output logic [31:0]      rd
);

  logic [31:0] active_r [8];
  logic [31:0] status_r;
  logic [31:0] saved_r;
  logic [31:0] shb_r [10];
  logic [31:0] slb_r [12];
  logic [31:0] ssb_r [5];

  logic [2:0]  bsel;
  logic [3:0]  sh_a;
  logic [3:0]  sl_a;
  logic [2:0]  ss_a;
  logic [31:0] link;
  logic [4:0]  entry_mode;

  always_comb begin
    bsel = (ctl.op == FOP_SAVE) ? ctl.cur : ctl.nxt;
    sh_a = ((bsel == BANK_FIQ) ? FIQ_HIGH_BASE : 4'd0) + {1'b0, ctl.step};
    sl_a = {bsel, 1'b0} + {3'd0, ctl.step == STEP_R14};
    ss_a = bsel - 3'd1;
    link = status_r[BIT_T] ? active_r[7] : active_r[7] - LINK_OFFSET;
    entry_mode = (ctl.act == ACT_FIQ) ? MODE_FIQ : MODE_IRQ;
  end

  always_comb begin
    rd = '0;
    if (ctl.act == ACT_READ) begin
      if (ctl.idx inside {[5'd8:5'd15]}) rd = active_r[ctl.idx[2:0]];
      else if (ctl.idx == IDX_SAVED) rd = saved_r;
      else if (ctl.idx == IDX_STATUS) rd = status_r;
    end
  end

  assign status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) active_r[i] <= '0;
      for (int i = 0; i < 10; i++) shb_r[i] <= '0;
      for (int i = 0; i < 12; i++) slb_r[i] <= '0;
      for (int i = 0; i < 5; i++) ssb_r[i] <= '0;
      status_r <= STATUS_RESET;
      saved_r  <= '0;
    end else begin
      case (ctl.op)
        FOP_SAVE: begin
          if (ctl.step < STEP_R13) shb_r[sh_a] <= active_r[ctl.step];
          else if (ctl.step != STEP_SPSR) slb_r[sl_a] <= active_r[ctl.step];
          else if (bsel != BANK_USR) ssb_r[ss_a] <= saved_r;
        end
        FOP_LOAD: begin
          if (ctl.step < STEP_R13) active_r[ctl.step] <= shb_r[sh_a];
          else if (ctl.step != STEP_SPSR) active_r[ctl.step] <= slb_r[sl_a];
          else if (bsel != BANK_USR) saved_r <= ssb_r[ss_a];
        end
        FOP_COMMIT: begin
          case (ctl.act)
            ACT_FIQ, ACT_IRQ: begin
              saved_r     <= status_r;
              status_r    <= {status_r[31:8], 1'b1,
                              (ctl.act == ACT_FIQ) | status_r[BIT_F], 1'b0, entry_mode};
              active_r[6] <= link;
              active_r[7] <= (ctl.act == ACT_FIQ) ? FIQ_PC : IRQ_PC;
            end
            ACT_STATUS: status_r <= ctl.val;
            ACT_WREG: begin
              if (ctl.idx inside {[5'd8:5'd15]}) active_r[ctl.idx[2:0]] <= ctl.val;
              else if (ctl.idx == IDX_SAVED) saved_r <= ctl.val;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/aebr_ctrl.sv =====
// command decode and bank-switch sequencer
`default_nettype none
module aebr_ctrl import aebr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_go,
  input  wire logic [1:0]  cmd,
  input  wire logic [4:0]  idx,
  input  wire logic [31:0] val,
  input  wire logic [13:0] latch,
  input  wire logic [13:0] mask,
  input  wire logic [31:0] status,
  input  wire logic        out_free,
  output logic             busy,
  output ctl_t             ctl,
  output res_t             res
);

  state_t      state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  act_t        act_r, act_nxt;
  logic [2:0]  cur_r, cur_nxt;
  logic [2:0]  nxt_r, nxt_nxt;
  cmd_t        cmd_r;
  logic [4:0]  idx_r;
  logic [31:0] val_r;
  logic [13:0] latch_r;

  logic [13:0] pend;
  logic        fiq_go, irq_go;
  bank_t       val_bank, cur_bank, tgt_bank;
  logic [4:0]  tmode;
  act_t        dec_act;
  logic        need_switch;

  // decision made once per item from the current status word
  always_comb begin
    pend     = latch_r & mask;
    fiq_go   = |(pend & FIQ_SOURCES) && !status[BIT_F];
    irq_go   = !fiq_go && |(pend & IRQ_SOURCES) && !status[BIT_I];
    val_bank = bank_of(val_r[4:0]);
    cur_bank = bank_of(status[4:0]);
    tmode    = val_r[4:0];
    dec_act  = ACT_NONE;
    case (cmd_r)
      CMD_POLL: begin
        dec_act = fiq_go ? ACT_FIQ : (irq_go ? ACT_IRQ : ACT_NONE);
        tmode   = fiq_go ? MODE_FIQ : MODE_IRQ;
      end
      CMD_STATUS: dec_act = val_bank.ok ? ACT_STATUS : ACT_ERR;
      CMD_WRITE:  dec_act = ACT_WREG;
      CMD_READ:   dec_act = ACT_READ;
      default:    dec_act = ACT_NONE;
    endcase
    tgt_bank    = bank_of(tmode);
    need_switch = (dec_act == ACT_FIQ || dec_act == ACT_IRQ || dec_act == ACT_STATUS)
                  && tmode != status[4:0];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    act_nxt   = act_r;
    cur_nxt   = cur_r;
    nxt_nxt   = nxt_r;
    case (state_r)
      S_IDLE: begin
        if (in_go) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        act_nxt   = dec_act;
        cur_nxt   = cur_bank.num;
        nxt_nxt   = tgt_bank.num;
        step_nxt  = '0;
        state_nxt = need_switch ? S_SAVE : S_DONE;
      end
      S_SAVE: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_SPSR) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_SPSR) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != S_IDLE);
    ctl.op   = FOP_IDLE;
    ctl.step = step_r;
    ctl.cur  = cur_r;
    ctl.nxt  = nxt_r;
    ctl.act  = act_r;
    ctl.idx  = idx_r;
    ctl.val  = val_r;
    res.push = 1'b0;
    case (state_r)
      S_SAVE: ctl.op = FOP_SAVE;
      S_LOAD: ctl.op = FOP_LOAD;
      S_DONE: begin
        if (out_free) begin
          ctl.op   = FOP_COMMIT;
          res.push = 1'b1;
        end
      end
      default: ctl.op = FOP_IDLE;
    endcase
    res.taken = (act_r == ACT_FIQ) ? TAKEN_FIQ :
                (act_r == ACT_IRQ) ? TAKEN_IRQ : TAKEN_NONE;
    res.err   = (act_r == ACT_ERR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      act_r   <= ACT_NONE;
      cur_r   <= BANK_USR;
      nxt_r   <= BANK_USR;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      act_r   <= act_nxt;
      cur_r   <= cur_nxt;
      nxt_r   <= nxt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_r   <= cmd_t'(cmd);
      idx_r   <= idx;
      val_r   <= val;
      latch_r <= latch;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the banked register file: directed table, random phases, live prediction
module tb_top import aebr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] rd;
    logic [1:0]  tk;
    logic        er;
  } bank_res_t;

  typedef struct {
    cmd_t        cmd;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [13:0] latch;
    bit          typed;
    logic [31:0] rd;
    logic [1:0]  tk;
    logic        er;
  } dir_row_t;

  localparam int NUM_DIR    = 29;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_LEN  = 115;
  localparam int HOLD_LEN   = 400;
  localparam int SETTLE     = 25;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [13:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // cmd, reg_index, write_value, irq_latch, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // read_data, taken, mode_error, zero pad

  arm_exception_entry_and_register_banking uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predictor state
  logic [31:0] gpr [8];
  logic [31:0] cpsr;
  logic [31:0] spsr;
  logic [31:0] hi_bank [10];
  logic [31:0] sl_bank [12];
  logic [31:0] spsr_bank [5];
  logic [13:0] en_mask;

  bank_res_t pending_res_q[$];
  bank_res_t got_exp;
  dir_row_t  dir_tab [NUM_DIR];
  logic [4:0] mode_list [7];

  int errors;
  int idle_in;
  int idle_out;
  int hold_left;
  bit hold_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int bank_num(input logic [4:0] m);
    case (m)
      MODE_USR, MODE_SYS: return 0;
      MODE_FIQ: return 1;
      MODE_IRQ: return 2;
      MODE_SVC: return 3;
      MODE_ABT: return 4;
      MODE_UND: return 5;
      default: return -1;
    endcase
  endfunction

  function automatic void clear_banked_file();
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    for (int i = 0; i < 10; i++) hi_bank[i] = '0;
    for (int i = 0; i < 12; i++) sl_bank[i] = '0;
    for (int i = 0; i < 5; i++) spsr_bank[i] = '0;
    cpsr    = STATUS_RESET;
    spsr    = '0;
    en_mask = '0;
  endfunction

  function automatic void mode_swap(input logic [4:0] m);
    int cur;
    int nxt;
    int hb;
    cur = bank_num(cpsr[4:0]);
    nxt = bank_num(m);
    if (cpsr[4:0] == m || nxt < 0) return;
    if (cur < 0) cur = 0;
    hb = (cur == 1) ? 5 : 0;
    for (int i = 0; i < 5; i++) hi_bank[hb + i] = gpr[i];
    sl_bank[cur * 2]     = gpr[5];
    sl_bank[cur * 2 + 1] = gpr[6];
    if (cur >= 1) spsr_bank[cur - 1] = spsr;
    hb = (nxt == 1) ? 5 : 0;
    for (int i = 0; i < 5; i++) gpr[i] = hi_bank[hb + i];
    gpr[5] = sl_bank[nxt * 2];
    gpr[6] = sl_bank[nxt * 2 + 1];
    if (nxt >= 1) spsr = spsr_bank[nxt - 1];
    cpsr[4:0] = m;
  endfunction

  function automatic void exc_enter(input logic [4:0] m, input logic [31:0] pc, input bit fbit);
    logic [31:0] link;
    logic [31:0] old;
    link = cpsr[BIT_T] ? gpr[7] : gpr[7] - 32'd4;
    old  = cpsr;
    mode_swap(m);
    spsr = old;
    cpsr[BIT_T] = 1'b0;
    cpsr[BIT_I] = 1'b1;
    if (fbit) cpsr[BIT_F] = 1'b1;
    gpr[6] = link;
    gpr[7] = pc;
  endfunction

  function automatic bank_res_t step_banked_file(input cmd_t c, input logic [4:0] idx,
                                                 input logic [31:0] v, input logic [13:0] l);
    bank_res_t r;
    logic [13:0] pend;
    r = '{rd: '0, tk: TAKEN_NONE, er: 1'b0};
    pend = l & en_mask;
    case (c)
      CMD_POLL: begin
        if (pend != '0) begin
          if (!cpsr[BIT_F] && (pend & FIQ_SOURCES) != '0) begin
            exc_enter(MODE_FIQ, FIQ_PC, 1'b1);
            r.tk = TAKEN_FIQ;
          end else if (!cpsr[BIT_I] && (pend & IRQ_SOURCES) != '0) begin
            exc_enter(MODE_IRQ, IRQ_PC, 1'b0);
            r.tk = TAKEN_IRQ;
          end
        end
      end
      CMD_STATUS: begin
        if (bank_num(v[4:0]) < 0) begin
          r.er = 1'b1;
        end else begin
          mode_swap(v[4:0]);
          cpsr = v;
        end
      end
      CMD_WRITE: begin
        if (idx >= 5'd8 && idx <= 5'd15) gpr[idx - 5'd8] = v;
        else if (idx == IDX_SAVED) spsr = v;
      end
      default: begin
        if (idx >= 5'd8 && idx <= 5'd15) r.rd = gpr[idx - 5'd8];
        else if (idx == IDX_SAVED) r.rd = spsr;
        else if (idx == IDX_STATUS) r.rd = cpsr;
      end
    endcase
    return r;
  endfunction

  task automatic issue(input cmd_t c, input logic [4:0] idx, input logic [31:0] v,
                       input logic [13:0] l, input bit typed, input bank_res_t tv);
    bank_res_t p;
    while (idle_in != 0 && $urandom_range(99, 0) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, l, v, idx, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = step_banked_file(c, idx, v, l);
    pending_res_q.push_back(typed ? tv : p);
  endtask

  task automatic issue_random();
    int r;
    cmd_t c;
    logic [4:0] idx;
    logic [31:0] v;
    logic [13:0] l;
    r   = $urandom_range(99, 0);
    v   = $urandom;
    l   = 14'($urandom);
    idx = ($urandom_range(99, 0) < 85) ? 5'($urandom_range(17, 8)) : 5'($urandom);
    if (r < 30) begin
      c = CMD_POLL;
      if ($urandom_range(1, 0) == 0) l = 14'(1) << $urandom_range(13, 0);
    end else if (r < 55) begin
      c = CMD_STATUS;
      if ($urandom_range(99, 0) < 85) begin
        v[4:0]  = mode_list[$urandom_range(6, 0)];
        v[BIT_I] = ($urandom_range(3, 0) == 0);
        v[BIT_F] = ($urandom_range(3, 0) == 0);
      end
    end else if (r < 75) begin
      c = CMD_WRITE;
    end else begin
      c = CMD_READ;
    end
    issue(c, idx, v, l, 1'b0, '{rd: '0, tk: TAKEN_NONE, er: 1'b0});
  endtask

  task automatic write_mask(input logic [13:0] m);
    in_tvalid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    en_mask = m;
  endtask

  // receiver side
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= idle_out);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res_q.size() == 0) begin
        $display("%0t: item with none expected, got %h", $time, out_tdata);
        errors++;
      end else begin
        got_exp = pending_res_q.pop_front();
        if (out_tdata[31:0] !== got_exp.rd) begin
          $display("%0t: read_data exp %h got %h", $time, got_exp.rd, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[33:32] !== got_exp.tk) begin
          $display("%0t: taken exp %0d got %0d", $time, got_exp.tk, out_tdata[33:32]);
          errors++;
        end
        if (out_tdata[34] !== got_exp.er) begin
          $display("%0t: mode_error exp %0d got %0d", $time, got_exp.er, out_tdata[34]);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [13:0] phase_mask [NUM_PHASES];
    errors     = 0;
    hold_left  = 0;
    hold_req   = 1'b0;
    idle_in    = 38;
    idle_out   = 67;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    mode_list  = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
    phase_mask = '{14'h0000, 14'($urandom), 14'h3FFF, FIQ_SOURCES, IRQ_SOURCES,
                   14'($urandom)};
    dir_tab = '{
      '{CMD_READ,   5'd17, 32'h0,        14'h0,    1'b1, STATUS_RESET, TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd8,  32'h0,        14'h0,    1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd16, 32'h0,        14'h0,    1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd31, 32'h0,        14'h3FFF, 1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_WRITE,  5'd8,  32'hFFFFFFFF, 14'h0,    1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd8,  32'h0,        14'h0,    1'b1, 32'hFFFFFFFF, TAKEN_NONE, 1'b0},
      '{CMD_WRITE,  5'd15, 32'h00001000, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_WRITE,  5'd16, 32'h12345678, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_WRITE,  5'd17, 32'hDEADBEEF, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_WRITE,  5'd0,  32'hCAFEF00D, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd17, 32'h0,        14'h0,    1'b1, STATUS_RESET, TAKEN_NONE, 1'b0},
      '{CMD_STATUS, 5'd0,  32'h00000000, 14'h0,    1'b1, 32'h0,        TAKEN_NONE, 1'b1},
      '{CMD_STATUS, 5'd0,  32'hFFFFFFF4, 14'h0,    1'b1, 32'h0,        TAKEN_NONE, 1'b1},
      '{CMD_POLL,   5'd0,  32'h0,        14'h3FFF, 1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_STATUS, 5'd0,  32'h00000013, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_POLL,   5'd0,  32'h0,        14'h0000, 1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_POLL,   5'd0,  32'h0,        14'h3FFF, 1'b1, 32'h0,        TAKEN_FIQ,  1'b0},
      '{CMD_READ,   5'd14, 32'h0,        14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd16, 32'h0,        14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_POLL,   5'd0,  32'h0,        14'h1F9F, 1'b1, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_STATUS, 5'd0,  32'h00000012, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_POLL,   5'd0,  32'h0,        14'h1F9F, 1'b1, 32'h0,        TAKEN_IRQ,  1'b0},
      '{CMD_STATUS, 5'd0,  32'h00000030, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_POLL,   5'd0,  32'h0,        14'h0080, 1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd14, 32'h0,        14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_STATUS, 5'd0,  32'h0000001F, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_STATUS, 5'd0,  32'h00000017, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_STATUS, 5'd0,  32'h0000001B, 14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0},
      '{CMD_READ,   5'd13, 32'h0,        14'h0,    1'b0, 32'h0,        TAKEN_NONE, 1'b0}
    };
    clear_banked_file();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mask(14'h3FFF);
    foreach (dir_tab[i]) begin
      issue(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].latch, dir_tab[i].typed,
            '{rd: dir_tab[i].rd, tk: dir_tab[i].tk, er: dir_tab[i].er});
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mask(phase_mask[p]);
      if (p < 2) begin
        idle_in  = 38;
        idle_out = 67;
      end else if (p < 4) begin
        idle_in  = 67;
        idle_out = 38;
      end else begin
        idle_in  = 0;
        idle_out = 0;
      end
      // long receiver stall while items keep coming
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < PHASE_LEN; k++) issue_random();
    end

    in_tvalid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_res_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
